@@ rtl/bap_pkg.sv @@
`default_nettype none

package bap_pkg;

   typedef enum logic [2:0] {
      PAT_OFF      = 3'd0,
      PAT_ARMED    = 3'd1,
      PAT_DISARMED = 3'd2,
      PAT_LOWVOLT  = 3'd3,
      PAT_CRITICAL = 3'd4,
      PAT_FAILSAFE = 3'd5,
      PAT_CALIB    = 3'd6
   } pattern_type;

   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam int TIME_W   = 32;
   localparam int RES_W    = 10;
   localparam int SUM_W    = 18;
   localparam int FOLD_W   = 13;
   localparam int TRIM_W   = 11;
   localparam int DIFF_W   = 12;

   localparam logic [TIME_W-1:0] T_100  = 32'd100;
   localparam logic [TIME_W-1:0] T_200  = 32'd200;
   localparam logic [TIME_W-1:0] T_300  = 32'd300;
   localparam logic [TIME_W-1:0] T_400  = 32'd400;

   // residues modulo one thousand
   localparam logic [SUM_W-1:0]  W_BYTE2   = 18'd536;
   localparam logic [SUM_W-1:0]  W_BYTE3   = 18'd216;
   localparam logic [FOLD_W-1:0] W_FOLD    = 13'd24;
   localparam logic [TRIM_W-1:0] MOD_BASE  = 11'd1000;
   localparam logic signed [DIFF_W-1:0] D_BASE = 12'sd1000;
   localparam logic signed [DIFF_W-1:0] D_WRAP = 12'sd296;

   localparam logic [RES_W-1:0] R_100 = 10'd100;
   localparam logic [RES_W-1:0] R_200 = 10'd200;
   localparam logic [RES_W-1:0] R_300 = 10'd300;
   localparam logic [RES_W-1:0] R_400 = 10'd400;
   localparam logic [RES_W-1:0] R_500 = 10'd500;
   localparam logic [RES_W-1:0] R_600 = 10'd600;
   localparam logic [RES_W-1:0] R_700 = 10'd700;
   localparam logic [RES_W-1:0] R_800 = 10'd800;
   localparam logic [RES_W-1:0] R_900 = 10'd900;

   typedef struct packed {
      logic              req_type;
      logic [2:0]        new_pattern;
      logic [TIME_W-1:0] now_ms;
   } req_data_type;

   typedef struct packed {
      logic       pin_level;
      logic [2:0] active_pattern;
   } rsp_data_type;

   typedef struct packed {
      req_data_type     req;
      logic [RES_W-1:0] now_res;
   } item_type;

   typedef struct packed {
      req_data_type     req;
      logic [SUM_W-1:0] part_sum;
   } part_type;

endpackage

`default_nettype wire

@@ rtl/buzzer_alert_pattern_sequencer.sv @@
`default_nettype none

// Buzzer alert pattern sequencer. Each request item is either a pattern set
// or an update tick stamped with a wrapping millisecond count; every item
// returns exactly one result with the buzzer pin level and the active
// pattern after it. One item is accepted per clock cycle while the result
// side is not stalling; each item passes two stages that reduce the
// timestamp modulo one thousand, then the pattern state update into the
// result register. Back-pressure on the result side stalls the whole
// pipeline. Reset silences the pin and selects the off pattern.
module buzzer_alert_pattern_sequencer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  bap_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output bap_pkg::rsp_data_type rsp_data
);

   logic              mid_valid;
   logic              mid_ready;
   bap_pkg::item_type mid_item;

   bap_residue u_residue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   bap_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/bap_residue.sv @@
`default_nettype none

module bap_residue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  bap_pkg::req_data_type in_item,
   output logic                  out_valid,
   input  wire                   out_ready,
   output bap_pkg::item_type     out_item
);

   logic                         s1_valid_ff, s1_valid_in;
   bap_pkg::part_type            s1_data_ff, s1_data_in;
   logic                         s2_valid_ff, s2_valid_in;
   bap_pkg::item_type            s2_data_ff, s2_data_in;
   logic                         s2_take, s1_take;
   logic [bap_pkg::SUM_W-1:0]    b0, b1, b2, b3;
   logic [bap_pkg::FOLD_W-1:0]   fold1;
   logic [bap_pkg::TRIM_W-1:0]   fold2;

   assign s2_take  = !s2_valid_ff || out_ready;
   assign s1_take  = !s1_valid_ff || s2_take;
   assign in_ready = s1_take;

   // byte weights of a 32-bit word reduced modulo one thousand
   always_comb begin
      b0 = {10'd0, in_item.now_ms[7:0]};
      b1 = {2'd0, in_item.now_ms[15:8], 8'd0};
      b2 = {10'd0, in_item.now_ms[23:16]} * bap_pkg::W_BYTE2;
      b3 = {10'd0, in_item.now_ms[31:24]} * bap_pkg::W_BYTE3;
      s1_data_in.req      = in_item;
      s1_data_in.part_sum = b0 + b1 + b2 + b3;
      s1_valid_in         = s1_take ? in_valid : s1_valid_ff;
   end

   // 1024 is 24 modulo one thousand: fold twice, then one trim
   always_comb begin
      fold1 = {3'd0, s1_data_ff.part_sum[9:0]}
            + {5'd0, s1_data_ff.part_sum[17:10]} * bap_pkg::W_FOLD;
      fold2 = {1'b0, fold1[9:0]} + 11'(({10'd0, fold1[12:10]}) * bap_pkg::W_FOLD);
      s2_data_in.req     = s1_data_ff.req;
      s2_data_in.now_res = (fold2 >= bap_pkg::MOD_BASE) ?
                           bap_pkg::RES_W'(fold2 - bap_pkg::MOD_BASE) :
                           bap_pkg::RES_W'(fold2);
      s2_valid_in        = s2_take ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_data_ff <= s1_data_in;
      end
      if (s2_take) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_data_ff;

endmodule

`default_nettype wire

@@ rtl/bap_core.sv @@
`default_nettype none

module bap_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  bap_pkg::item_type     in_item,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output bap_pkg::rsp_data_type rsp_data
);

   bap_pkg::pattern_type           pattern_ff, pattern_in;
   logic [bap_pkg::TIME_W-1:0]     start_ff, start_in;
   logic [bap_pkg::RES_W-1:0]      start_res_ff, start_res_in;
   logic                           gap_ff, gap_in;
   logic [1:0]                     beeps_ff, beeps_in;
   logic                           pin_ff, pin_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bap_pkg::rsp_data_type          rsp_data_ff;
   logic                           advance;
   logic [bap_pkg::TIME_W-1:0]     elapsed;
   logic signed [bap_pkg::DIFF_W-1:0] diff;
   logic [bap_pkg::RES_W-1:0]      e_res;
   logic                           lowvolt_on, critical_on;
   bap_pkg::req_data_type          req;

   assign req      = in_item.req;
   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && in_ready;

   // elapsed time and its residue modulo one thousand; 2^32 leaves 296
   always_comb begin
      elapsed = req.now_ms - start_ff;
      diff    = $signed({2'b00, in_item.now_res}) - $signed({2'b00, start_res_ff});
      if (req.now_ms < start_ff) begin
         diff = diff + bap_pkg::D_WRAP;
      end
      if (diff < 0) begin
         diff = diff + bap_pkg::D_BASE;
      end else if (diff >= bap_pkg::D_BASE) begin
         diff = diff - bap_pkg::D_BASE;
      end
      e_res       = bap_pkg::RES_W'(diff);
      lowvolt_on  = e_res < bap_pkg::R_200;
      critical_on = (e_res < bap_pkg::R_100)
                 || (e_res >= bap_pkg::R_200 && e_res < bap_pkg::R_300)
                 || (e_res >= bap_pkg::R_400 && e_res < bap_pkg::R_500)
                 || (e_res >= bap_pkg::R_600 && e_res < bap_pkg::R_700)
                 || (e_res >= bap_pkg::R_800 && e_res < bap_pkg::R_900);
   end

   always_comb begin
      pattern_in   = pattern_ff;
      start_in     = start_ff;
      start_res_in = start_res_ff;
      gap_in       = gap_ff;
      beeps_in     = beeps_ff;
      pin_in       = pin_ff;
      if (req.req_type == bap_pkg::REQ_SET) begin
         // code seven and a repeat of the active pattern are ignored
         if (req.new_pattern <= bap_pkg::PAT_CALIB && req.new_pattern != pattern_ff) begin
            pattern_in   = bap_pkg::pattern_type'(req.new_pattern);
            start_in     = req.now_ms;
            start_res_in = in_item.now_res;
            gap_in       = 1'b0;
            beeps_in     = 2'd0;
            if (req.new_pattern == bap_pkg::PAT_OFF) begin
               pin_in = 1'b0;
            end
         end
      end else begin
         unique case (pattern_ff)
            bap_pkg::PAT_OFF: begin
               pin_in = 1'b0;
            end
            bap_pkg::PAT_ARMED: begin
               if (elapsed < bap_pkg::T_100) begin
                  pin_in = 1'b1;
               end else if (elapsed < bap_pkg::T_200) begin
                  pin_in = 1'b0;
               end else begin
                  pattern_in = bap_pkg::PAT_OFF;
               end
            end
            bap_pkg::PAT_DISARMED: begin
               if (elapsed < bap_pkg::T_300) begin
                  pin_in = 1'b1;
               end else if (elapsed < bap_pkg::T_400) begin
                  pin_in = 1'b0;
               end else begin
                  pattern_in = bap_pkg::PAT_OFF;
               end
            end
            bap_pkg::PAT_LOWVOLT: begin
               pin_in = lowvolt_on;
            end
            bap_pkg::PAT_CRITICAL: begin
               pin_in = critical_on;
            end
            bap_pkg::PAT_FAILSAFE: begin
               pin_in = 1'b1;
            end
            bap_pkg::PAT_CALIB: begin
               if (beeps_ff < 2'd2) begin
                  if (!gap_ff) begin
                     if (elapsed < bap_pkg::T_100) begin
                        pin_in = 1'b1;
                     end else begin
                        pin_in       = 1'b0;
                        gap_in       = 1'b1;
                        start_in     = req.now_ms;
                        start_res_in = in_item.now_res;
                     end
                  end else if (elapsed > bap_pkg::T_100) begin
                     gap_in       = 1'b0;
                     start_in     = req.now_ms;
                     start_res_in = in_item.now_res;
                     beeps_in     = beeps_ff + 2'd1;
                  end
               end else begin
                  pattern_in = bap_pkg::PAT_OFF;
               end
            end
            default: begin
               pin_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= bap_pkg::PAT_OFF;
         start_ff     <= '0;
         start_res_ff <= '0;
         gap_ff       <= 1'b0;
         beeps_ff     <= 2'd0;
         pin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pattern_ff   <= pattern_in;
            start_ff     <= start_in;
            start_res_ff <= start_res_in;
            gap_ff       <= gap_in;
            beeps_ff     <= beeps_in;
            pin_ff       <= pin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.pin_level      <= pin_in;
         rsp_data_ff.active_pattern <= pattern_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
